### src/mips_subset_instruction_executor_unit_defines.svh
// ----------------------------------------------------------------------------
// MIPS subset executor assertion macros
// Shared concurrent assertion forms for the executor's RTL.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define MSEU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define MSEU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

### src/mipsx_pkg.sv
// ----------------------------------------------------------------------------
// MIPS subset executor package
// Item types, request structs, codes and helper functions of the executor.
// ----------------------------------------------------------------------------
package mipsx_pkg;

  localparam int STORE_BYTES_DEF = 16384;
  localparam int CODE_BASE_DEF   = 8192;
  localparam int WORD_W          = 32;
  localparam int BYTE_W          = 8;
  localparam int NUM_REGS        = 32;
  localparam int LANES           = 4;

  localparam logic OP_EXEC   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [2:0] STAT_EXECUTED  = 3'd0;
  localparam logic [2:0] STAT_NO_INSTR  = 3'd1;
  localparam logic [2:0] STAT_INSERTED  = 3'd2;
  localparam logic [2:0] STAT_UNKNOWN   = 3'd3;
  localparam logic [2:0] STAT_OUT_RANGE = 3'd4;
  localparam logic [2:0] STAT_FULL      = 3'd5;

  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_LW   = 3'd2;
  localparam logic [2:0] KIND_SW   = 3'd3;
  localparam logic [2:0] KIND_BEQ  = 3'd4;
  localparam logic [2:0] KIND_J    = 3'd5;
  localparam logic [2:0] KIND_NONE = 3'd6;

  localparam logic [5:0] OPC_RTYPE = 6'd0;
  localparam logic [5:0] OPC_J     = 6'd2;
  localparam logic [5:0] OPC_BEQ   = 6'd4;
  localparam logic [5:0] OPC_LW    = 6'd35;
  localparam logic [5:0] OPC_SW    = 6'd43;
  localparam logic [5:0] FN_ADD    = 6'd32;
  localparam logic [5:0] FN_SUB    = 6'd34;

  typedef struct packed {
    logic        op;
    logic [31:0] instr_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  kind;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [13:0] mem_address;
  } out_item_t;

  typedef struct packed {
    logic        rd_en;
    logic [31:0] rd_addr;
    logic        wr_en;
    logic        mark_en;
    logic        mark_val;
    logic [31:0] wr_addr;
    logic [31:0] wr_data;
  } store_req_t;

  typedef struct packed {
    logic        rd_en;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic        we;
    logic [4:0]  wa;
    logic [31:0] wd;
  } rf_req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_FETCH,
    S_DECODE,
    S_EXEC,
    S_LOAD
  } st_t;

  function automatic logic [31:0] reg_reset_value(logic [4:0] idx);
    logic [31:0] v;
    v = '0;
    if (idx >= 5'd8 && idx <= 5'd15) begin
      v = 32'(idx);
    end else if (idx >= 5'd16 && idx <= 5'd23) begin
      v = {25'd0, idx, 2'b00};
    end
    return v;
  endfunction

  function automatic logic [7:0] be_byte(logic [31:0] word, logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0: b = word[31:24];
      2'd1: b = word[23:16];
      2'd2: b = word[15:8];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

endpackage

### src/mipsx_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mipsx_ram #(
  parameter int WIDTH = mipsx_pkg::WORD_W,
  parameter int DEPTH = mipsx_pkg::NUM_REGS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/mipsx_store.sv
// ----------------------------------------------------------------------------
// Banked byte store
// Four byte lanes of data and valid marks, so that any word, aligned or not,
// is read or written in a single access.
// ----------------------------------------------------------------------------
module mipsx_store #(
  parameter int STORE_BYTES = mipsx_pkg::STORE_BYTES_DEF
) (
  input  logic                   clk,
  input  mipsx_pkg::store_req_t  req,
  output logic [31:0]            rd_word,
  output logic                   rd_mark
);
  import mipsx_pkg::*;

  localparam int ROWS = (STORE_BYTES + LANES - 1) / LANES;
  localparam int RW   = $clog2(ROWS);

  logic [1:0]        rd_lane_r;
  logic [BYTE_W-1:0] byte_q [LANES];
  logic              mark_q [LANES];

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_lane_r <= req.rd_addr[1:0];
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [1:0]    wk;
    logic [RW-1:0] wrow;
    logic [RW-1:0] rrow;

    assign wk   = 2'(b) - req.wr_addr[1:0];
    assign wrow = req.wr_addr[RW+1:2] + RW'(2'(b) < req.wr_addr[1:0]);
    assign rrow = req.rd_addr[RW+1:2] + RW'(2'(b) < req.rd_addr[1:0]);

    mipsx_ram #(.WIDTH(BYTE_W), .DEPTH(ROWS)) u_data (
      .clk   (clk),
      .we    (req.wr_en),
      .waddr (wrow),
      .wdata (be_byte(req.wr_data, wk)),
      .re    (req.rd_en),
      .raddr (rrow),
      .rdata (byte_q[b])
    );

    mipsx_ram #(.WIDTH(1), .DEPTH(ROWS)) u_mark (
      .clk   (clk),
      .we    (req.wr_en && req.mark_en),
      .waddr (wrow),
      .wdata (req.mark_val),
      .re    (req.rd_en),
      .raddr (rrow),
      .rdata (mark_q[b])
    );
  end

  always_comb begin
    logic [1:0] lane;
    lane    = '0;
    rd_word = '0;
    for (int k = 0; k < LANES; k++) begin
      lane = rd_lane_r + 2'(k);
      rd_word[WORD_W-1-BYTE_W*k -: BYTE_W] = byte_q[lane];
    end
  end

  assign rd_mark = mark_q[rd_lane_r];

endmodule

### src/mipsx_regfile.sv
// ----------------------------------------------------------------------------
// Register file
// Two RAM copies written together, giving two read ports for rs and rt.
// ----------------------------------------------------------------------------
module mipsx_regfile (
  input  logic               clk,
  input  mipsx_pkg::rf_req_t req,
  output logic [31:0]        rs_val,
  output logic [31:0]        rt_val
);
  import mipsx_pkg::*;

  mipsx_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_copy_a (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.wa),
    .wdata (req.wd),
    .re    (req.rd_en),
    .raddr (req.ra),
    .rdata (rs_val)
  );

  mipsx_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_copy_b (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.wa),
    .wdata (req.wd),
    .re    (req.rd_en),
    .raddr (req.rb),
    .rdata (rt_val)
  );

endmodule

### src/mips_subset_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// MIPS subset instruction executor
// Inserts program words into a byte store and executes add, sub, lw, sw,
// beq and j from it, one item per instruction or insert.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that zeroes the byte store and
// its valid marks and loads the register reset values; no item is taken
// during it. The store is split into four byte lanes, so a whole word at any
// byte address is read or written in a single access. An insert, or an
// execute item whose PC lies outside the store, ends in the fetch state;
// any other goes through store fetch, register read (it ends there if its
// word is not marked valid) and execute, and lw also through a load state,
// as its data makes a second pass through the store lanes. A one-item input
// register takes the next item while the current one executes; a result
// waits in an output register, and while it is stalled no result can follow.
`include "mips_subset_instruction_executor_unit_defines.svh"

module mips_subset_instruction_executor_unit #(
  parameter int STORE_BYTES = mipsx_pkg::STORE_BYTES_DEF,
  parameter int CODE_BASE   = mipsx_pkg::CODE_BASE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mipsx_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mipsx_pkg::out_item_t out_item
);
  import mipsx_pkg::*;

  localparam int ROWS    = (STORE_BYTES + LANES - 1) / LANES;
  localparam int CLR_LEN = (ROWS > NUM_REGS) ? ROWS : NUM_REGS;
  localparam int CW      = $clog2(CLR_LEN);
  localparam int IP_MAX  = (STORE_BYTES > CODE_BASE) ? STORE_BYTES : CODE_BASE;
  localparam int IPW     = $clog2(IP_MAX + 1);

  st_t         st_r, st_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic [IPW-1:0] ip_r, ip_nxt;
  logic [CW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [31:0] instr_r, instr_nxt;
  logic [13:0] ld_maddr_r, ld_maddr_nxt;
  logic        buf_valid_r;
  in_item_t    buf_r;
  logic        out_valid_r;
  out_item_t   out_r, out_nxt;

  logic        buf_pop;
  logic        out_load;
  logic        out_free;
  store_req_t  store_req;
  rf_req_t     rf_req;
  logic [31:0] st_word;
  logic        st_mark;
  logic [31:0] rs_val;
  logic [31:0] rt_val;

  logic [5:0]  opc;
  logic [5:0]  funct;
  logic [4:0]  rd_idx;
  logic [4:0]  rt_idx;
  logic [31:0] offs;
  logic [31:0] addr;
  logic [31:0] pc4;
  logic [31:0] ip_ext;

  function automatic logic span_ok(logic [31:0] a);
    return (33'(a) + 33'd4) <= 33'(STORE_BYTES);
  endfunction

  mipsx_store #(.STORE_BYTES(STORE_BYTES)) u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_word (st_word),
    .rd_mark (st_mark)
  );

  mipsx_regfile u_regfile (
    .clk    (clk),
    .req    (rf_req),
    .rs_val (rs_val),
    .rt_val (rt_val)
  );

  assign opc    = instr_r[31:26];
  assign funct  = instr_r[5:0];
  assign rd_idx = instr_r[15:11];
  assign rt_idx = instr_r[20:16];
  assign offs   = {{14{instr_r[15]}}, instr_r[15:0], 2'b00};
  assign addr   = rs_val + offs;
  assign pc4    = pc_r + 32'd4;
  assign ip_ext = 32'(ip_r);

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = buf_valid_r || (st_r == S_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= 32'(CODE_BASE);
      ip_r        <= IPW'(CODE_BASE);
      buf_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pc_r      <= pc_nxt;
      ip_r      <= ip_nxt;
      if (in_valid && !in_stall) begin
        buf_valid_r <= 1'b1;
      end else if (buf_pop) begin
        buf_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    instr_r    <= instr_nxt;
    ld_maddr_r <= ld_maddr_nxt;
    if (in_valid && !in_stall) begin
      buf_r <= in_item;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    st_nxt       = st_r;
    pc_nxt       = pc_r;
    ip_nxt       = ip_r;
    clr_cnt_nxt  = clr_cnt_r;
    instr_nxt    = instr_r;
    ld_maddr_nxt = ld_maddr_r;
    buf_pop      = 1'b0;
    out_load     = 1'b0;
    out_nxt      = '0;
    out_nxt.kind = KIND_NONE;
    store_req    = '0;
    rf_req       = '0;

    case (st_r)
      S_CLEAR: begin
        store_req.wr_en   = {1'b0, clr_cnt_r} < (CW+1)'(ROWS);
        store_req.mark_en = 1'b1;
        store_req.wr_addr = 32'(clr_cnt_r) << 2;
        rf_req.we         = {1'b0, clr_cnt_r} < (CW+1)'(NUM_REGS);
        rf_req.wa         = clr_cnt_r[4:0];
        rf_req.wd         = reg_reset_value(clr_cnt_r[4:0]);
        clr_cnt_nxt       = clr_cnt_r + CW'(1);
        if (clr_cnt_r == CW'(CLR_LEN - 1)) begin
          st_nxt = S_FETCH;
        end
      end

      S_FETCH: begin
        if (buf_valid_r) begin
          if (buf_r.op == OP_INSERT) begin
            if (out_free) begin
              buf_pop  = 1'b1;
              out_load = 1'b1;
              if (span_ok(ip_ext)) begin
                store_req.wr_en    = 1'b1;
                store_req.mark_en  = 1'b1;
                store_req.mark_val = 1'b1;
                store_req.wr_addr  = ip_ext;
                store_req.wr_data  = buf_r.instr_word;
                out_nxt.status      = STAT_INSERTED;
                out_nxt.mem_written = 1'b1;
                out_nxt.mem_address = ip_ext[13:0];
                ip_nxt = ip_r + IPW'(4);
              end else begin
                out_nxt.status = STAT_FULL;
              end
            end
          end else if (!span_ok(pc_r)) begin
            if (out_free) begin
              buf_pop        = 1'b1;
              out_load       = 1'b1;
              out_nxt.status = STAT_OUT_RANGE;
            end
          end else begin
            buf_pop           = 1'b1;
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = pc_r;
            st_nxt            = S_DECODE;
          end
        end
      end

      S_DECODE: begin
        if (!st_mark) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_nxt.status = STAT_NO_INSTR;
            st_nxt         = S_FETCH;
          end
        end else begin
          instr_nxt    = st_word;
          rf_req.rd_en = 1'b1;
          rf_req.ra    = st_word[25:21];
          rf_req.rb    = st_word[20:16];
          st_nxt       = S_EXEC;
        end
      end

      S_EXEC: begin
        case (opc)
          OPC_RTYPE: begin
            if (out_free) begin
              out_load = 1'b1;
              pc_nxt   = pc4;
              st_nxt   = S_FETCH;
              if (funct == FN_ADD || funct == FN_SUB) begin
                out_nxt.kind        = (funct == FN_ADD) ? KIND_ADD : KIND_SUB;
                out_nxt.reg_value   = (funct == FN_ADD) ? rs_val + rt_val
                                                        : rs_val - rt_val;
                out_nxt.reg_written = 1'b1;
                out_nxt.reg_index   = rd_idx;
                rf_req.we           = 1'b1;
                rf_req.wa           = rd_idx;
                rf_req.wd           = out_nxt.reg_value;
              end
            end
          end
          OPC_LW: begin
            if (!span_ok(addr)) begin
              if (out_free) begin
                out_load            = 1'b1;
                out_nxt.status      = STAT_OUT_RANGE;
                out_nxt.kind        = KIND_LW;
                out_nxt.mem_address = addr[13:0];
                st_nxt              = S_FETCH;
              end
            end else begin
              store_req.rd_en   = 1'b1;
              store_req.rd_addr = addr;
              ld_maddr_nxt      = addr[13:0];
              st_nxt            = S_LOAD;
            end
          end
          OPC_SW: begin
            if (out_free) begin
              out_load            = 1'b1;
              out_nxt.kind        = KIND_SW;
              out_nxt.mem_address = addr[13:0];
              st_nxt              = S_FETCH;
              if (!span_ok(addr)) begin
                out_nxt.status = STAT_OUT_RANGE;
              end else begin
                store_req.wr_en     = 1'b1;
                store_req.wr_addr   = addr;
                store_req.wr_data   = rt_val;
                out_nxt.mem_written = 1'b1;
                pc_nxt              = pc4;
              end
            end
          end
          OPC_BEQ: begin
            if (out_free) begin
              out_load     = 1'b1;
              out_nxt.kind = KIND_BEQ;
              pc_nxt       = (rs_val == rt_val) ? pc4 + offs : pc4;
              st_nxt       = S_FETCH;
            end
          end
          OPC_J: begin
            if (out_free) begin
              out_load     = 1'b1;
              out_nxt.kind = KIND_J;
              pc_nxt       = {4'b0000, instr_r[25:0], 2'b00};
              st_nxt       = S_FETCH;
            end
          end
          default: begin
            if (out_free) begin
              out_load       = 1'b1;
              out_nxt.status = STAT_UNKNOWN;
              st_nxt         = S_FETCH;
            end
          end
        endcase
      end

      S_LOAD: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.kind        = KIND_LW;
          out_nxt.reg_written = 1'b1;
          out_nxt.reg_index   = rt_idx;
          out_nxt.reg_value   = st_word;
          out_nxt.mem_address = ld_maddr_r;
          rf_req.we           = 1'b1;
          rf_req.wa           = rt_idx;
          rf_req.wd           = st_word;
          pc_nxt              = pc4;
          st_nxt              = S_FETCH;
        end
      end

      default: begin
        st_nxt = S_FETCH;
      end
    endcase

    out_nxt.next_pc = pc_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `MSEU_ASSERT(a_pc_held, clk, rst_n, (out_load && (out_nxt.status == STAT_NO_INSTR || out_nxt.status == STAT_UNKNOWN || out_nxt.status == STAT_OUT_RANGE)) |=> (pc_r == $past(pc_r)), "PC moved on a failed item")
  `MSEU_ASSERT(a_ip_step, clk, rst_n, (out_load && out_nxt.status == STAT_INSERTED) |=> (ip_r == $past(ip_r) + IPW'(4)), "Insert position did not advance by one word")
  `MSEU_ASSERT(a_clear_quiet, clk, rst_n, (st_r == S_CLEAR) |-> (!out_valid_r && !buf_valid_r), "Item activity during the clearing pass")
  `MSEU_ASSERT_NEVER(a_store_rw, clk, rst_n, store_req.wr_en && store_req.rd_en, "Store read and write in one cycle")
  `MSEU_ASSERT_NEVER(a_rf_rw, clk, rst_n, rf_req.we && rf_req.rd_en, "Register file read and write in one cycle")

endmodule

### dv/mipsx_checker.sv
// ----------------------------------------------------------------------------
// MIPS subset executor checker
// Watches both item channels of the executor. Each accepted input item runs
// through a cycle-free model of the register file, byte store, valid marks
// and program counter, and the outcome is queued. Each accepted result is
// compared field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module mipsx_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  mipsx_pkg::in_item_t  in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  mipsx_pkg::out_item_t out_item,
  output int                   mismatches,
  output int                   open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import mipsx_pkg::*;

  logic [31:0] gpr [NUM_REGS];
  logic [7:0]  mem_bytes [STORE_BYTES_DEF];
  logic        mem_marks [STORE_BYTES_DEF];
  logic [31:0] pc;
  logic [31:0] slot;

  out_item_t outcomes_due [$];
  out_item_t want;
  int        fails = 0;

  function automatic void reset_state();
    for (int i = 0; i < NUM_REGS; i++) begin
      gpr[i] = (i >= 8 && i <= 15) ? 32'(i) : (i >= 16 && i <= 23) ? 32'(4 * i) : '0;
    end
    for (int i = 0; i < STORE_BYTES_DEF; i++) begin
      mem_bytes[i] = '0;
      mem_marks[i] = 1'b0;
    end
    pc   = CODE_BASE_DEF;
    slot = CODE_BASE_DEF;
  endfunction

  function automatic logic word_fits(logic [31:0] a);
    return ({32'd0, a} + 64'd4) <= 64'(STORE_BYTES_DEF);
  endfunction

  function automatic logic [31:0] get_bytes(logic [31:0] a);
    return {mem_bytes[a], mem_bytes[a + 1], mem_bytes[a + 2], mem_bytes[a + 3]};
  endfunction

  function automatic void put_bytes(logic [31:0] a, logic [31:0] w);
    mem_bytes[a]     = w[31:24];
    mem_bytes[a + 1] = w[23:16];
    mem_bytes[a + 2] = w[15:8];
    mem_bytes[a + 3] = w[7:0];
  endfunction

  function automatic out_item_t expected_outcome(in_item_t it);
    out_item_t   r;
    logic [31:0] w;
    logic [31:0] off;
    logic [31:0] ea;
    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    r = '0;
    r.status = STAT_EXECUTED;
    r.kind = KIND_NONE;
    if (it.op == OP_INSERT) begin
      r.status = STAT_FULL;
      if (word_fits(slot)) begin
        put_bytes(slot, it.instr_word);
        for (int k = 0; k < LANES; k++) begin
          mem_marks[slot + k] = 1'b1;
        end
        r.status = STAT_INSERTED;
        r.mem_written = 1'b1;
        r.mem_address = slot[13:0];
        slot += 4;
      end
    end else if (!word_fits(pc)) begin
      r.status = STAT_OUT_RANGE;
    end else if (!mem_marks[pc]) begin
      r.status = STAT_NO_INSTR;
    end else begin
      w   = get_bytes(pc);
      opc = w[31:26];
      rs  = w[25:21];
      rt  = w[20:16];
      rd  = w[15:11];
      fn  = w[5:0];
      off = {{14{w[15]}}, w[15:0], 2'b00};
      ea  = gpr[rs] + off;
      case (opc)
        OPC_RTYPE: begin
          if (fn == FN_ADD || fn == FN_SUB) begin
            r.kind = (fn == FN_ADD) ? KIND_ADD : KIND_SUB;
            r.reg_value = (fn == FN_ADD) ? gpr[rs] + gpr[rt] : gpr[rs] - gpr[rt];
            r.reg_written = 1'b1;
            r.reg_index = rd;
            gpr[rd] = r.reg_value;
          end
          pc += 4;
        end
        OPC_LW, OPC_SW: begin
          r.kind = (opc == OPC_LW) ? KIND_LW : KIND_SW;
          r.mem_address = ea[13:0];
          if (!word_fits(ea)) begin
            r.status = STAT_OUT_RANGE;
          end else begin
            if (opc == OPC_LW) begin
              r.reg_value = get_bytes(ea);
              r.reg_written = 1'b1;
              r.reg_index = rt;
              gpr[rt] = r.reg_value;
            end else begin
              put_bytes(ea, gpr[rt]);
              r.mem_written = 1'b1;
            end
            pc += 4;
          end
        end
        OPC_BEQ: begin
          r.kind = KIND_BEQ;
          pc = (gpr[rs] == gpr[rt]) ? pc + 4 + off : pc + 4;
        end
        OPC_J: begin
          r.kind = KIND_J;
          pc = {4'd0, w[25:0], 2'b00};
        end
        default: begin
          r.status = STAT_UNKNOWN;
        end
      endcase
    end
    r.next_pc = pc;
    return r;
  endfunction

  function automatic int differs(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v === want_v) begin
      return 0;
    end
    $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_state();
      outcomes_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: result %0h arrived with no item outstanding", $time, out_item);
          fails++;
        end else begin
          want = outcomes_due.pop_front();
          fails += differs("status", want.status, out_item.status)
                 + differs("kind", want.kind, out_item.kind)
                 + differs("next_pc", want.next_pc, out_item.next_pc)
                 + differs("reg_written", want.reg_written, out_item.reg_written)
                 + differs("reg_index", want.reg_index, out_item.reg_index)
                 + differs("reg_value", want.reg_value, out_item.reg_value)
                 + differs("mem_written", want.mem_written, out_item.mem_written)
                 + differs("mem_address", want.mem_address, out_item.mem_address);
        end
      end
      if (in_valid && !in_stall) begin
        outcomes_due.push_back(expected_outcome(in_item));
      end
    end
    open_count <= outcomes_due.size();
    mismatches <= fails;
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// MIPS subset executor testbench
// Loads short programs into the executor and steps through them. A directed
// program covers every instruction, register and address extremes, backward
// branches taken and untaken, a taken forward branch and skipped junk words.
// Random segments of well-formed code follow, with jumps over random junk
// words and extra steps past the last inserted word. The run ends on one
// randomly chosen stuck condition.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mipsx_pkg::*;

  localparam logic [5:0] FN_UNUSED = 6'h3F;

  typedef enum {
    END_BAD_OPCODE,
    END_LOAD_OUT,
    END_STORE_OUT,
    END_PC_OUT,
    END_NO_CODE
  } ending_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      calm = 1'b0;
  int        mismatches;
  int        open_count;
  int        items = 0;
  int        words_in = 0;

  mips_subset_instruction_executor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  mipsx_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 29);
  end

  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sh, logic [5:0] fn);
    return {OPC_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(logic [25:0] target);
    return {OPC_J, target};
  endfunction

  // Destinations stay clear of r8..r23 so those keep their reset values as
  // address bases.
  function automatic logic [4:0] dest_reg();
    logic [4:0] r;
    r = 5'($urandom_range(15));
    return (r < 8) ? r : r + 5'd16;
  endfunction

  function automatic logic [31:0] safe_word(output logic is_branch);
    int         pick;
    int         bv;
    int         lo;
    int         hi;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] base;
    logic [5:0] fn;
    pick = $urandom_range(99);
    rs = 5'($urandom);
    rt = 5'($urandom);
    base = 5'($urandom_range(23, 8));
    bv = (base <= 15) ? base : 4 * base;
    lo = -(bv / 4);
    is_branch = 1'b0;
    if (pick < 24) begin
      return enc_r(rs, rt, dest_reg(), 5'($urandom), FN_ADD);
    end
    if (pick < 44) begin
      return enc_r(rs, rt, dest_reg(), 5'($urandom), FN_SUB);
    end
    if (pick < 66) begin
      hi = (STORE_BYTES_DEF - 4 - bv) / 4;
      return enc_i(OPC_LW, base, dest_reg(), 16'($urandom_range(hi - lo) + lo));
    end
    if (pick < 82) begin
      hi = (CODE_BASE_DEF - 4 - bv) / 4;
      return enc_i(OPC_SW, base, rt, 16'($urandom_range(hi - lo) + lo));
    end
    if (pick < 94) begin
      is_branch = 1'b1;
      if (pick < 88) begin
        rt = rs;
      end
      return enc_i(OPC_BEQ, rs, rt, 16'($urandom_range(3)));
    end
    fn = 6'($urandom);
    if (fn == FN_ADD || fn == FN_SUB) begin
      fn = fn + 6'd1;
    end
    return enc_r(rs, rt, 5'($urandom), 5'($urandom), fn);
  endfunction

  task automatic push_item(input logic op, input logic [31:0] word);
    calm <= (items >= 180 && items < 280);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{op: op, instr_word: word};
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items++;
  endtask

  task automatic put_word(input logic [31:0] w);
    push_item(OP_INSERT, w);
    words_in++;
  endtask

  task automatic execute_one();
    push_item(OP_EXEC, $urandom);
  endtask

  task automatic run_directed();
    put_word(enc_r(5'd8, 5'd16, 5'd1, 5'd0, FN_ADD));
    put_word(enc_r(5'd8, 5'd23, 5'd31, 5'd0, FN_SUB));
    put_word(enc_i(OPC_SW, 5'd0, 5'd31, 16'd0));
    put_word(enc_i(OPC_LW, 5'd9, 5'd3, -16'sd2));
    put_word(enc_i(OPC_SW, 5'd23, 5'd31, 16'((CODE_BASE_DEF - 4 - 92) / 4)));
    put_word(enc_i(OPC_LW, 5'd16, 5'd4, 16'((STORE_BYTES_DEF - 4 - 64) / 4)));
    put_word(enc_r(5'd31, 5'd31, 5'd7, 5'd31, FN_UNUSED));
    put_word(enc_r(5'd5, 5'd8, 5'd5, 5'd0, FN_ADD));
    put_word(enc_i(OPC_BEQ, 5'd5, 5'd8, -16'sd2));
    put_word(enc_i(OPC_BEQ, 5'd0, 5'd0, 16'd1));
    put_word(32'hFFFF_FFFF);
    put_word(enc_j(26'((CODE_BASE_DEF + 4 * 13) >> 2)));
    put_word($urandom);
    repeat (14) execute_one();
  endtask

  task automatic run_random();
    int          n;
    int          budget;
    int          skip;
    int          since_branch;
    logic        br;
    logic [31:0] w;
    since_branch = 3;
    while (items < 450) begin
      n = $urandom_range(5, 1);
      budget = 0;
      for (int s = 0; s < n; s++) begin
        if (since_branch >= 3 && $urandom_range(9) == 0) begin
          skip = $urandom_range(4, 1);
          put_word(enc_j(26'((CODE_BASE_DEF + 4 * (words_in + skip)) >> 2)));
          repeat (skip - 1) put_word($urandom);
          since_branch += skip;
        end else begin
          w = safe_word(br);
          put_word(w);
          since_branch = br ? 0 : since_branch + 1;
        end
        budget++;
      end
      repeat (budget + $urandom_range(2)) execute_one();
    end
  endtask

  task automatic run_ending();
    ending_t     tail;
    logic [5:0]  opc;
    logic [31:0] w;
    repeat (4) put_word(enc_r(5'd1, 5'd1, 5'd1, 5'd0, FN_ADD));
    tail = ending_t'($urandom_range(4));
    case (tail)
      END_BAD_OPCODE: begin
        do begin
          opc = 6'($urandom);
        end while (opc == OPC_RTYPE || opc == OPC_J || opc == OPC_BEQ ||
                   opc == OPC_LW || opc == OPC_SW);
        w = {opc, 26'($urandom)};
      end
      END_LOAD_OUT: begin
        w = enc_i(OPC_LW, 5'd23, 5'd1, 16'h7FFF);
      end
      END_STORE_OUT: begin
        w = enc_i(OPC_SW, 5'd16, 5'd1, 16'h8000);
      end
      END_PC_OUT: begin
        w = enc_j(26'h3FF_FFFF);
      end
      default: begin
        w = enc_j(26'($urandom_range(CODE_BASE_DEF / 4 - 1)));
      end
    endcase
    put_word(w);
    repeat (8) execute_one();
    execute_one();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    run_ending();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/mipsx_pkg.sv
src/mipsx_ram.sv
src/mipsx_store.sv
src/mipsx_regfile.sv
src/mips_subset_instruction_executor_unit.sv
dv/mipsx_checker.sv
dv/tb.sv
